@@ rtl/lru_key_value_cache_unit_assert.svh @@
// Assertion macros for the LRU key-value cache.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LKV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;

    localparam logic             ACT_GET    = 1'b0;
    localparam logic             ACT_PUT    = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

endpackage

@@ rtl/lkv_req_if.sv @@
// ----------------------------------------------------------------------------
// lkv_req_if
// Request channel: valid/ready handshake carrying one get or put word.
// ----------------------------------------------------------------------------
interface lkv_req_if import lkv_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);

endinterface

@@ rtl/lkv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: valid/ready handshake carrying one get result word.
// ----------------------------------------------------------------------------
interface lkv_rsp_if import lkv_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);

endinterface

@@ rtl/lkv_in_stage.sv @@
// ----------------------------------------------------------------------------
// lkv_in_stage
// Input register: captures one request word, released when the core takes it.
// ----------------------------------------------------------------------------
module lkv_in_stage import lkv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    lkv_req_if.sink    req,
    output req_t       head,
    output logic       head_valid,
    input  logic       pop
);

    logic valid_reg;
    logic valid_next;
    req_t data_reg;
    logic load;

    assign req.ready  = !valid_reg || pop;
    assign load       = req.valid && req.ready;
    assign head       = data_reg;
    assign head_valid = valid_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.action <= req.action;
            data_reg.key    <= req.key;
            data_reg.value  <= req.value;
        end
    end

endmodule

@@ rtl/lkv_out_stage.sv @@
// ----------------------------------------------------------------------------
// lkv_out_stage
// Result register: holds one get result until the consumer takes it.
// ----------------------------------------------------------------------------
module lkv_out_stage import lkv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rsp_t       data,
    output logic       can_take,
    lkv_rsp_if.source  rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign can_take       = !valid_reg || rsp.ready;
    assign rsp.valid      = valid_reg;
    assign rsp.found      = data_reg.found;
    assign rsp.read_value = data_reg.read_value;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= data;
        end
    end

endmodule

@@ rtl/lkv_core.sv @@
// ----------------------------------------------------------------------------
// lkv_core
// Entry store with parallel key match, recency ranks and combinational update.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_assert.svh"

module lkv_core import lkv_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  req_t             head,
    input  logic             head_valid,
    input  logic             res_can_take,
    output logic             pop,
    output logic             res_push,
    output rsp_t             res_data
);

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]  rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]  rank_next [MAX_ENTRIES];
    logic [DATA_W-1:0] key_reg   [MAX_ENTRIES];
    logic [DATA_W-1:0] val_reg   [MAX_ENTRIES];

    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  occ_m1;
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] old_vec;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  old_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  hit_rank;
    logic              hit;
    logic              evict;
    logic              is_put;
    logic              write_slot;

    // Capacity zero acts as one; anything above the store size saturates.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (int'(capacity_reg) > MAX_ENTRIES)
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    assign occ_m1 = occ_reg - CNT_W'(1);

    // Keys are unique among valid entries, and valid ranks are a permutation
    // of 0..occ-1, so both match vectors are one-hot or empty.
    always_comb
    begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == head.key);
            old_vec[i] = valid_reg[i] && (rank_reg[i] == occ_m1[IDX_W-1:0]);
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (old_vec[i])
            begin
                old_idx = old_idx | IDX_W'(i);
            end
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |hit_vec;
    assign hit_rank = rank_reg[hit_idx];
    assign evict    = (occ_reg >= eff_cap);
    assign is_put   = (head.action == ACT_PUT);

    always_comb
    begin
        priority if (hit)
        begin
            slot = hit_idx;
        end
        else if (evict)
        begin
            slot = old_idx;
        end
        else
        begin
            slot = free_idx;
        end
    end

    // A get needs room in the result register; a put never produces a word.
    assign pop        = head_valid && (is_put || res_can_take);
    assign res_push   = pop && !is_put;
    assign write_slot = pop && is_put;

    assign res_data.found      = hit;
    assign res_data.read_value = hit ? val_reg[hit_idx] : MISS_VALUE;

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (pop && hit)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            rank_next[slot] = '0;
        end
        else if (write_slot)
        begin
            // Insert: every surviving entry ages by one.
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && !(evict && (IDX_W'(i) == slot)))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            rank_next[slot]  = '0;
            valid_next[slot] = 1'b1;
            if (!evict)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            occ_reg      <= '0;
            valid_reg    <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_slot)
        begin
            key_reg[slot] <= head.key;
            val_reg[slot] <= head.value;
        end
    end

    `LKV_ASSERT_IMPLY(a_hit_onehot, 1'b1, $onehot0(hit_vec), "key matches more than one entry")
    `LKV_ASSERT_IMPLY(a_occ_count, 1'b1, $countones(valid_reg) == int'(occ_reg),
                      "occupancy out of step with valid entries")
    `LKV_ASSERT_IMPLY(a_evict_target, pop && is_put && !hit && evict, $onehot(old_vec),
                      "no unique least recent entry to evict")
    `LKV_ASSERT_NEXT(a_touch_rank, pop && hit, rank_reg[$past(hit_idx)] == '0,
                     "touched entry is not most recent")

endmodule

@@ rtl/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | word
//  --------+-----+------------------+--------------------------------
//  req     | in  | valid / ready    | action, key, value
//  rsp     | out | valid / ready    | found, read_value (gets only)
//  cfg     | in  | cfg_we, no ready | cfg_wdata = capacity
//
//  One request word per cycle while no get is held by a stalled result register;
//  match, rank update and write are combinational between the input register
//  and the result register, so a get result is valid on rsp from the result
//  register. The rate is set by the combinational 16-entry rank update.
//  Reset empties the cache and sets capacity to 16; no clearing pass.
//  A stalled result register holds further gets in the input register;
//  puts keep flowing while a result waits.
module lru_key_value_cache_unit import lkv_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    lkv_req_if.sink          req,
    lkv_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    req_t head;
    logic head_valid;
    logic pop;
    logic res_push;
    logic res_can_take;
    rsp_t res_data;

    lkv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    lkv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .head_valid   (head_valid),
        .res_can_take (res_can_take),
        .pop          (pop),
        .res_push     (res_push),
        .res_data     (res_data)
    );

    lkv_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data     (res_data),
        .can_take (res_can_take),
        .rsp      (rsp)
    );

endmodule
